// ===== rtl/ppp3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp3_pkg
// Shared widths, types and helpers for the point-on-plane projection pipeline.
// ----------------------------------------------------------------------------
package ppp3_pkg;

   localparam int FracBits = 16;
   localparam int CoordW   = 32;
   localparam int DiffW    = CoordW + 1;
   localparam int ProdW    = CoordW + DiffW;
   localparam int SumW     = ProdW + 3;
   localparam int WideW    = 2 * CoordW;
   localparam int HalfW    = CoordW;
   localparam int PartLoW  = HalfW + 1 + CoordW;
   localparam int NumW     = WideW + CoordW + 2;
   localparam int TW       = NumW + 2;
   localparam int DvW      = WideW + 1;
   localparam int ClampExp = 40;
   localparam int QBits    = ClampExp + 1;
   localparam int HiW      = TW - QBits;

   localparam int NumDots  = 5;
   localparam int IdxAA    = 0;
   localparam int IdxAB    = 1;
   localparam int IdxBB    = 2;
   localparam int IdxAD    = 3;
   localparam int IdxBD    = 4;

   localparam logic signed [SumW-1:0] Half  = SumW'(1) <<< (FracBits - 1);
   localparam logic signed [SumW-1:0] SatHi = SumW'(2147483647);
   localparam logic signed [SumW-1:0] SatLo = ~SatHi;
   localparam logic [QBits-1:0]       QClamp = QBits'(1) << ClampExp;

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      logic            neg;
      logic [TW-1:0]   t;
      coord_type       org;
   } div_lane_type;

   typedef struct packed {
      logic            zero;
      logic [DvW-1:0]  dv;
   } div_shared_type;

   function automatic coord_type sat_coord(input logic signed [SumW-1:0] v);
      coord_type r;
      if (v > SatHi) begin
         r = SatHi[CoordW-1:0];
      end else if (v < SatLo) begin
         r = SatLo[CoordW-1:0];
      end else begin
         r = v[CoordW-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/project_point_on_plane_3d_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// project_point_on_plane_3d_unit
// Orthogonal projection of a point onto a plane spanned by two tangents,
// signed fixed point, saturated outputs, degenerate flag on zero determinant.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  point, origin, tangent_a/b xyz
//   rsp_      out        rsp_valid/rsp_stall  proj xyz, degenerate
//
// One transaction per cycle while no held result stalls the output: 3 Gram stages,
// 7 solve stages, 43 divider stages (setup, one quotient bit per stage, output).
// Reset clears all valid bits; no state survives between transactions.
// rsp_stall with a held result freezes the whole pipeline and raises req_stall.
// ----------------------------------------------------------------------------
module project_point_on_plane_3d_unit
   import ppp3_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire coord_type   req_point_x,
   input  wire coord_type   req_point_y,
   input  wire coord_type   req_point_z,
   input  wire coord_type   req_origin_x,
   input  wire coord_type   req_origin_y,
   input  wire coord_type   req_origin_z,
   input  wire coord_type   req_tangent_a_x,
   input  wire coord_type   req_tangent_a_y,
   input  wire coord_type   req_tangent_a_z,
   input  wire coord_type   req_tangent_b_x,
   input  wire coord_type   req_tangent_b_y,
   input  wire coord_type   req_tangent_b_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output coord_type        rsp_proj_x,
   output coord_type        rsp_proj_y,
   output coord_type        rsp_proj_z,
   output logic             rsp_degenerate
);

   logic            advance;
   coord_type       pt [3], org [3], ta [3], tb [3];
   logic            gram_valid;
   coord_type       dot [NumDots];
   coord_type       g_org [3], g_ta [3], g_tb [3];
   logic            solve_valid;
   div_lane_type    lane [3];
   div_shared_type  sh;
   coord_type       res [3];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   assign pt  = '{req_point_x, req_point_y, req_point_z};
   assign org = '{req_origin_x, req_origin_y, req_origin_z};
   assign ta  = '{req_tangent_a_x, req_tangent_a_y, req_tangent_a_z};
   assign tb  = '{req_tangent_b_x, req_tangent_b_y, req_tangent_b_z};

   ppp3_gram u_gram (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .pt_in     (pt),
      .org_in    (org),
      .ta_in     (ta),
      .tb_in     (tb),
      .out_valid (gram_valid),
      .dot_out   (dot),
      .org_out   (g_org),
      .ta_out    (g_ta),
      .tb_out    (g_tb)
   );

   ppp3_solve u_solve (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (gram_valid),
      .dot_in    (dot),
      .org_in    (g_org),
      .ta_in     (g_ta),
      .tb_in     (g_tb),
      .out_valid (solve_valid),
      .lane_out  (lane),
      .sh_out    (sh)
   );

   ppp3_div u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (solve_valid),
      .lane_in    (lane),
      .sh_in      (sh),
      .out_valid  (rsp_valid),
      .res_out    (res),
      .degenerate (rsp_degenerate)
   );

   assign rsp_proj_x = res[0];
   assign rsp_proj_y = res[1];
   assign rsp_proj_z = res[2];

   a_zero_det_divisor: assert property (@(posedge clock) disable iff (reset)
      solve_valid && sh.zero |-> sh.dv == '0)
      else $error("zero determinant flag out of step with divisor");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(solve_valid) && $stable(gram_valid))
      else $error("pipeline moved while output held");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !gram_valid && !solve_valid)
      else $error("valid bits survive reset");

endmodule
`default_nettype wire

// ===== rtl/ppp3_gram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp3_gram
// Three stages: offset from origin, dot-product terms, rounded saturated sums.
// ----------------------------------------------------------------------------
module ppp3_gram
   import ppp3_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      in_valid,
   input  wire coord_type pt_in  [3],
   input  wire coord_type org_in [3],
   input  wire coord_type ta_in  [3],
   input  wire coord_type tb_in  [3],
   output logic           out_valid,
   output coord_type      dot_out [NumDots],
   output coord_type      org_out [3],
   output coord_type      ta_out  [3],
   output coord_type      tb_out  [3]
);

   logic                      v1_ff, v2_ff, v3_ff;
   logic signed [DiffW-1:0]   d_ff    [3];
   logic signed [DiffW-1:0]   d_in    [3];
   coord_type                 org1_ff [3], org2_ff [3], org3_ff [3];
   coord_type                 ta1_ff  [3], ta2_ff  [3], ta3_ff  [3];
   coord_type                 tb1_ff  [3], tb2_ff  [3], tb3_ff  [3];
   logic signed [ProdW-1:0]   prod_ff [NumDots][3];
   logic signed [ProdW-1:0]   prod_in [NumDots][3];
   coord_type                 dot_ff  [NumDots];
   coord_type                 dot_in  [NumDots];

   always_comb begin
      logic signed [SumW-1:0] acc;
      acc = '0;
      for (int c = 0; c < 3; c++) begin
         d_in[c] = DiffW'(pt_in[c]) - DiffW'(org_in[c]);
         prod_in[IdxAA][c] = ProdW'(ta1_ff[c]) * ProdW'(ta1_ff[c]);
         prod_in[IdxAB][c] = ProdW'(ta1_ff[c]) * ProdW'(tb1_ff[c]);
         prod_in[IdxBB][c] = ProdW'(tb1_ff[c]) * ProdW'(tb1_ff[c]);
         prod_in[IdxAD][c] = ProdW'(ta1_ff[c]) * ProdW'(d_ff[c]);
         prod_in[IdxBD][c] = ProdW'(tb1_ff[c]) * ProdW'(d_ff[c]);
      end
      for (int k = 0; k < NumDots; k++) begin
         acc = '0;
         for (int c = 0; c < 3; c++) begin
            acc = acc + ((SumW'(prod_ff[k][c]) + Half) >>> FracBits);
         end
         dot_in[k] = sat_coord(acc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff    <= d_in;
         org1_ff <= org_in;
         ta1_ff  <= ta_in;
         tb1_ff  <= tb_in;
         prod_ff <= prod_in;
         org2_ff <= org1_ff;
         ta2_ff  <= ta1_ff;
         tb2_ff  <= tb1_ff;
         dot_ff  <= dot_in;
         org3_ff <= org2_ff;
         ta3_ff  <= ta2_ff;
         tb3_ff  <= tb2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign dot_out   = dot_ff;
   assign org_out   = org3_ff;
   assign ta_out    = ta3_ff;
   assign tb_out    = tb3_ff;

endmodule
`default_nettype wire

// ===== rtl/ppp3_solve.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp3_solve
// Seven stages: determinant and Cramer numerators, wide numerator products
// in 32-bit partials, magnitude and divider operand setup.
// ----------------------------------------------------------------------------
module ppp3_solve
   import ppp3_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      in_valid,
   input  wire coord_type dot_in [NumDots],
   input  wire coord_type org_in [3],
   input  wire coord_type ta_in  [3],
   input  wire coord_type tb_in  [3],
   output logic           out_valid,
   output div_lane_type   lane_out [3],
   output div_shared_type sh_out
);

   localparam int MDet0 = 0;
   localparam int MDet1 = 1;
   localparam int MN00  = 2;
   localparam int MN01  = 3;
   localparam int MN10  = 4;
   localparam int MN11  = 5;

   logic [6:0]                vld_ff;
   logic signed [WideW-1:0]   m_ff   [6];
   logic signed [WideW-1:0]   m_in   [6];
   logic signed [WideW-1:0]   det_ff, num0_ff, num1_ff;
   logic signed [WideW-1:0]   det_in, num0_in, num1_in;
   logic signed [PartLoW-1:0] plo0_ff [3], plo1_ff [3], plo0_in [3], plo1_in [3];
   logic signed [WideW-1:0]   phi0_ff [3], phi1_ff [3], phi0_in [3], phi1_in [3];
   logic signed [NumW-1:0]    w0_ff [3], w1_ff [3], w0_in [3], w1_in [3];
   logic signed [NumW-1:0]    n_ff [3], n_in [3];
   logic [NumW-1:0]           mag_ff [3], mag_in [3];
   logic                      neg_ff [3], neg_in [3];
   logic [WideW-1:0]          ad6_ff, ad7_ff, ad8_ff, ad9_ff, ad_in;
   logic                      z6_ff, z7_ff, z8_ff, z9_ff;
   logic                      dn6_ff, dn7_ff, dn8_ff;
   coord_type                 org4_ff [3], org5_ff [3], org6_ff [3];
   coord_type                 org7_ff [3], org8_ff [3], org9_ff [3];
   coord_type                 ta4_ff [3], ta5_ff [3], tb4_ff [3], tb5_ff [3];
   div_lane_type              lane_ff [3], lane_in [3];
   div_shared_type            sh_ff, sh_in;

   always_comb begin
      m_in[MDet0] = WideW'(dot_in[IdxAA]) * WideW'(dot_in[IdxBB]);
      m_in[MDet1] = WideW'(dot_in[IdxAB]) * WideW'(dot_in[IdxAB]);
      m_in[MN00]  = WideW'(dot_in[IdxBB]) * WideW'(dot_in[IdxAD]);
      m_in[MN01]  = WideW'(dot_in[IdxAB]) * WideW'(dot_in[IdxBD]);
      m_in[MN10]  = WideW'(dot_in[IdxAA]) * WideW'(dot_in[IdxBD]);
      m_in[MN11]  = WideW'(dot_in[IdxAB]) * WideW'(dot_in[IdxAD]);
      det_in  = m_ff[MDet0] - m_ff[MDet1];
      num0_in = m_ff[MN00] - m_ff[MN01];
      num1_in = m_ff[MN10] - m_ff[MN11];
      ad_in   = det_ff[WideW-1] ? WideW'(-det_ff) : WideW'(det_ff);
      for (int c = 0; c < 3; c++) begin
         plo0_in[c] = $signed({1'b0, num0_ff[HalfW-1:0]}) * ta5_ff[c];
         phi0_in[c] = $signed(num0_ff[WideW-1:HalfW]) * ta5_ff[c];
         plo1_in[c] = $signed({1'b0, num1_ff[HalfW-1:0]}) * tb5_ff[c];
         phi1_in[c] = $signed(num1_ff[WideW-1:HalfW]) * tb5_ff[c];
         w0_in[c]   = (NumW'(phi0_ff[c]) <<< HalfW) + NumW'(plo0_ff[c]);
         w1_in[c]   = (NumW'(phi1_ff[c]) <<< HalfW) + NumW'(plo1_ff[c]);
         n_in[c]    = w0_ff[c] + w1_ff[c];
         neg_in[c]  = n_ff[c][NumW-1] ^ dn8_ff;
         mag_in[c]  = n_ff[c][NumW-1] ? NumW'(-n_ff[c]) : NumW'(n_ff[c]);
         lane_in[c].neg = neg_ff[c];
         lane_in[c].t   = {1'b0, mag_ff[c], 1'b0} + TW'(ad9_ff);
         lane_in[c].org = org9_ff[c];
      end
      sh_in.zero = z9_ff;
      sh_in.dv   = {ad9_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff    <= m_in;
         org4_ff <= org_in;
         ta4_ff  <= ta_in;
         tb4_ff  <= tb_in;
         det_ff  <= det_in;
         num0_ff <= num0_in;
         num1_ff <= num1_in;
         org5_ff <= org4_ff;
         ta5_ff  <= ta4_ff;
         tb5_ff  <= tb4_ff;
         plo0_ff <= plo0_in;
         phi0_ff <= phi0_in;
         plo1_ff <= plo1_in;
         phi1_ff <= phi1_in;
         ad6_ff  <= ad_in;
         z6_ff   <= (det_ff == '0);
         dn6_ff  <= det_ff[WideW-1];
         org6_ff <= org5_ff;
         w0_ff   <= w0_in;
         w1_ff   <= w1_in;
         ad7_ff  <= ad6_ff;
         z7_ff   <= z6_ff;
         dn7_ff  <= dn6_ff;
         org7_ff <= org6_ff;
         n_ff    <= n_in;
         ad8_ff  <= ad7_ff;
         z8_ff   <= z7_ff;
         dn8_ff  <= dn7_ff;
         org8_ff <= org7_ff;
         neg_ff  <= neg_in;
         mag_ff  <= mag_in;
         ad9_ff  <= ad8_ff;
         z9_ff   <= z8_ff;
         org9_ff <= org8_ff;
         lane_ff <= lane_in;
         sh_ff   <= sh_in;
      end
   end

   assign out_valid = vld_ff[6];
   assign lane_out  = lane_ff;
   assign sh_out    = sh_ff;

endmodule
`default_nettype wire

// ===== rtl/ppp3_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp3_div
// Pipelined restoring divider, one quotient bit per stage on three lanes,
// with rounding offset, magnitude clamp, origin add and saturation.
// ----------------------------------------------------------------------------
module ppp3_div
   import ppp3_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic           in_valid,
   input  wire div_lane_type   lane_in [3],
   input  wire div_shared_type sh_in,
   output logic                out_valid,
   output coord_type           res_out [3],
   output logic                degenerate
);

   logic [QBits:0]      vld_ff;
   logic [DvW-1:0]      r_ff   [QBits+1][3];
   logic [DvW-1:0]      r_in   [QBits+1][3];
   logic [QBits-1:0]    q_ff   [QBits+1][3];
   logic [QBits-1:0]    q_in   [QBits+1][3];
   logic [QBits-1:0]    tl_ff  [QBits+1][3];
   logic [QBits-1:0]    tl_in  [QBits+1][3];
   logic                ovf_ff [QBits+1][3];
   logic                ovf_in [QBits+1][3];
   logic                neg_ff [QBits+1][3];
   logic                neg_in [QBits+1][3];
   coord_type           org_ff [QBits+1][3];
   coord_type           org_in [QBits+1][3];
   div_shared_type      sh_ff  [QBits+1];
   div_shared_type      shs_in [QBits+1];
   coord_type           res_ff [3];
   coord_type           res_in [3];
   logic                out_vld_ff;
   logic                deg_ff;

   always_comb begin
      logic [HiW-1:0]            hi;
      logic [DvW:0]              r2;
      logic [DvW:0]              dvx;
      logic [QBits-1:0]          mag;
      logic signed [SumW-1:0]    qs;
      hi  = '0;
      r2  = '0;
      dvx = '0;
      mag = '0;
      qs  = '0;
      for (int c = 0; c < 3; c++) begin
         hi = lane_in[c].t[TW-1:QBits];
         r_in[0][c]   = DvW'(hi);
         ovf_in[0][c] = (DvW'(hi) >= sh_in.dv);
         q_in[0][c]   = '0;
         tl_in[0][c]  = lane_in[c].t[QBits-1:0];
         neg_in[0][c] = lane_in[c].neg;
         org_in[0][c] = lane_in[c].org;
      end
      shs_in[0] = sh_in;
      for (int s = 1; s <= QBits; s++) begin
         shs_in[s] = sh_ff[s-1];
         dvx = {1'b0, sh_ff[s-1].dv};
         for (int c = 0; c < 3; c++) begin
            r2 = {r_ff[s-1][c], tl_ff[s-1][c][QBits-s]};
            if (r2 >= dvx) begin
               r_in[s][c] = DvW'(r2 - dvx);
               q_in[s][c] = q_ff[s-1][c] | (QBits'(1) << (QBits - s));
            end else begin
               r_in[s][c] = DvW'(r2);
               q_in[s][c] = q_ff[s-1][c];
            end
            tl_in[s][c]  = tl_ff[s-1][c];
            ovf_in[s][c] = ovf_ff[s-1][c];
            neg_in[s][c] = neg_ff[s-1][c];
            org_in[s][c] = org_ff[s-1][c];
         end
      end
      for (int c = 0; c < 3; c++) begin
         if (ovf_ff[QBits][c] || (q_ff[QBits][c] > QClamp)) begin
            mag = QClamp;
         end else begin
            mag = q_ff[QBits][c];
         end
         qs = SumW'(mag);
         if (neg_ff[QBits][c]) begin
            qs = -qs;
         end
         if (sh_ff[QBits].zero) begin
            res_in[c] = org_ff[QBits][c];
         end else begin
            res_in[c] = sat_coord(qs + SumW'(org_ff[QBits][c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= {vld_ff[QBits-1:0], in_valid};
         out_vld_ff <= vld_ff[QBits];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff   <= r_in;
         q_ff   <= q_in;
         tl_ff  <= tl_in;
         ovf_ff <= ovf_in;
         neg_ff <= neg_in;
         org_ff <= org_in;
         sh_ff  <= shs_in;
         res_ff <= res_in;
         deg_ff <= sh_ff[QBits].zero;
      end
   end

   assign out_valid  = out_vld_ff;
   assign res_out    = res_ff;
   assign degenerate = deg_ff;

endmodule
`default_nettype wire
